// File: src/cartridge_bank_controller_defines.svh
// ---------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Shared concurrent assertion forms. They expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// Condition must hold at every edge outside reset
`define CBC_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cbc_pkg.sv
// ---------------------------------------------------------------------------
// Cartridge bank controller package
// Item types, access and register codes, constants and the
// controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package cbc_pkg;

  // Access codes carried in the cmd field
  typedef enum logic [1:0] {
    CMD_ROM_READ   = 2'd0,
    CMD_CTRL_WRITE = 2'd1,
    CMD_RAM_READ   = 2'd2,
    CMD_RAM_WRITE  = 2'd3
  } cmd_t;

  // Control register regions, upper two bits of reg_select
  typedef enum logic [1:0] {
    REGION_RAM_ENABLE = 2'd0,
    REGION_BANK_LOW   = 2'd1,
    REGION_BANK_HIGH  = 2'd2,
    REGION_MODE       = 2'd3
  } region_t;

  localparam logic [3:0]  ENABLE_KEY     = 4'hA;
  localparam logic [15:0] ROM_BANK_BASE  = 16'h4000;
  localparam logic [15:0] ROM_WINDOW_END = 16'h8000;
  localparam logic [7:0]  READ_FILL      = 8'hFF;
  localparam int          ROM_OFFSET_W   = 14;   // bytes per ROM bank, log2
  localparam int          RAM_BANK_W     = 13;   // bytes per RAM bank, log2
  localparam int          RAM_IDX_W      = 17;   // offset plus bank base

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [2:0]  reg_select;
    logic [7:0]  write_data;
  } req_item_t;

  typedef struct packed {
    logic        rom_fetch;
    logic [20:0] rom_address;
    logic [7:0]  read_data;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // take the input item, apply control writes
    logic step_quot;  // index quotient estimate
    logic step_rem;   // index remainder
    logic mem_en;     // RAM read or write
    logic load_out;   // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ram_access; // current input item goes to RAM
  } dp_status_t;

endpackage

// File: src/cbc_channels.sv
// ---------------------------------------------------------------------------
// Cartridge bank controller channels
// Valid/ready channels for access items, result items and configuration.
// ---------------------------------------------------------------------------
interface cbc_req_if import cbc_pkg::*;;
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbc_rsp_if import cbc_pkg::*;;
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/cbc_datapath.sv
// ---------------------------------------------------------------------------
// Cartridge bank controller datapath
// Bank registers, ROM address translation, RAM index reduction and
// the external RAM, plus the output payload register.
// ---------------------------------------------------------------------------
module cbc_datapath import cbc_pkg::*; #(
  parameter int RAM_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  req_item_t   in_item,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output rsp_item_t   out_item
);

  localparam int AW       = $clog2(RAM_DEPTH);
  localparam int RECIP    = (1 << RAM_IDX_W) / RAM_DEPTH;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = RAM_IDX_W + RECIP_W;

  // Control state
  logic [15:0] ram_size;
  logic        ram_enabled;
  logic        banking_mode;
  logic [6:0]  bank;

  // Per-item registers
  logic                 op_write;
  logic                 op_read_ram;
  logic [7:0]           op_data;
  logic [RAM_IDX_W-1:0] op_idx;
  logic                 res_fetch;
  logic [20:0]          res_addr;
  logic [7:0]           res_fill;
  logic [RECIP_W-1:0]   quot;
  logic [AW-1:0]        rem_idx;
  logic [7:0]           ram_q;
  logic [7:0]           mem [RAM_DEPTH];

  logic                 ram_ok;
  logic                 is_ram_cmd;
  logic [6:0]           bank_eff;
  logic                 rom_fetch_c;
  logic [20:0]          rom_addr_c;
  logic [7:0]           fill_c;
  logic [RAM_IDX_W-1:0] idx_c;
  logic [PROD_W-1:0]    prod;
  logic [RAM_IDX_W-1:0] qd;
  logic [RAM_IDX_W-1:0] diff;
  logic [RAM_IDX_W-1:0] rem_c;

  // Access decode on the incoming item
  always_comb begin
    ram_ok     = ram_enabled && (in_item.address < ram_size);
    is_ram_cmd = (in_item.cmd == CMD_RAM_READ) || (in_item.cmd == CMD_RAM_WRITE);
    bank_eff   = banking_mode ? {2'b00, bank[4:0]} : bank;
    idx_c      = {1'b0, in_item.address};
    if (banking_mode) begin
      idx_c = idx_c + {2'b00, bank[6:5], {RAM_BANK_W{1'b0}}};
    end
    rom_fetch_c = 1'b0;
    rom_addr_c  = '0;
    fill_c      = 8'h00;
    case (in_item.cmd)
      CMD_ROM_READ: begin
        if (in_item.address < ROM_BANK_BASE) begin
          rom_fetch_c = 1'b1;
          rom_addr_c  = {5'b00000, in_item.address};
        end else if (in_item.address < ROM_WINDOW_END) begin
          rom_fetch_c = 1'b1;
          rom_addr_c  = {bank_eff, in_item.address[ROM_OFFSET_W-1:0]};
        end else begin
          fill_c = READ_FILL;
        end
      end
      CMD_RAM_READ: fill_c = ram_ok ? 8'h00 : READ_FILL;
      default:      fill_c = 8'h00;
    endcase
  end

  assign status.ram_access = is_ram_cmd && ram_ok;

  // Configuration and control register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_size     <= '0;
      ram_enabled  <= 1'b0;
      banking_mode <= 1'b0;
      bank         <= 7'd1;
    end else begin
      if (cfg_we) begin
        ram_size <= cfg_data;
      end
      if (cmd.latch && in_item.cmd == CMD_CTRL_WRITE) begin
        case (region_t'(in_item.reg_select[2:1]))
          REGION_RAM_ENABLE: ram_enabled <= (in_item.write_data[3:0] == ENABLE_KEY);
          REGION_BANK_LOW: begin
            bank[4:0] <= (in_item.write_data[4:0] == 5'd0) ? 5'd1 : in_item.write_data[4:0];
          end
          REGION_BANK_HIGH:  bank[6:5] <= in_item.write_data[6:5];
          REGION_MODE:       banking_mode <= (in_item.write_data != 8'h00);
          default:           banking_mode <= banking_mode;
        endcase
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_write    <= (in_item.cmd == CMD_RAM_WRITE);
      op_read_ram <= (in_item.cmd == CMD_RAM_READ) && ram_ok;
      op_data     <= in_item.write_data;
      op_idx      <= idx_c;
      res_fetch   <= rom_fetch_c;
      res_addr    <= rom_addr_c;
      res_fill    <= fill_c;
    end
  end

  // Index modulo RAM depth: reciprocal estimate, then one correction
  assign prod = PROD_W'(op_idx) * PROD_W'(RECIP);
  assign qd   = RAM_IDX_W'(quot) * RAM_IDX_W'(RAM_DEPTH);
  assign diff = op_idx - qd;
  assign rem_c = (diff >= RAM_IDX_W'(RAM_DEPTH)) ? diff - RAM_IDX_W'(RAM_DEPTH) : diff;

  always_ff @(posedge clk) begin
    if (cmd.step_quot) begin
      quot <= prod[RAM_IDX_W +: RECIP_W];
    end
    if (cmd.step_rem) begin
      rem_idx <= rem_c[AW-1:0];
    end
  end

  // External RAM, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_en) begin
      if (op_write) begin
        mem[rem_idx] <= op_data;
      end
      ram_q <= mem[rem_idx];
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.rom_fetch   <= res_fetch;
      out_item.rom_address <= res_addr;
      out_item.read_data   <= op_read_ram ? ram_q : res_fill;
    end
  end

endmodule

// File: src/cbc_ctrl.sv
// ---------------------------------------------------------------------------
// Cartridge bank controller sequencer
// Walks one item through capture, index reduction and RAM access (RAM items
// that reach the RAM only) and output load; owns the handshake flags.
// ---------------------------------------------------------------------------
module cbc_ctrl import cbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_QUOT = 5'b00010,
    S_REM  = 5'b00100,
    S_MEM  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Datapath commands
  always_comb begin
    cmd.latch     = accept;
    cmd.step_quot = (state == S_QUOT);
    cmd.step_rem  = (state == S_REM);
    cmd.mem_en    = (state == S_MEM);
    cmd.load_out  = (state == S_OUT) && (!rsp_valid || rsp_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = status.ram_access ? S_QUOT : S_OUT;
        end
      end
      S_QUOT: state_next = S_REM;
      S_REM:  state_next = S_MEM;
      S_MEM:  state_next = S_OUT;
      S_OUT: begin
        if (cmd.load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/cartridge_bank_controller.sv
// ---------------------------------------------------------------------------
// Cartridge bank controller: ROM, control and refused RAM items go from capture
// straight to the output load; RAM accesses that reach the RAM first pass through
// index reduction and the RAM port. One item in flight; a result still held by
// the receiver delays the next load. Config writes always taken. Sync reset: RAM
// off, banking mode off, bank 1, RAM size 0.
// ---------------------------------------------------------------------------
`include "cartridge_bank_controller_defines.svh"

module cartridge_bank_controller import cbc_pkg::*; #(
  parameter int RAM_DEPTH = 32768
) (
  input logic        clk,
  input logic        rst,
  cbc_cfg_if.sink    cfg,
  cbc_req_if.sink    req,
  cbc_rsp_if.source  rsp
);

  dp_cmd_t    ctl_cmd;
  dp_status_t ctl_status;
  rsp_item_t  out_item;

  // Configuration is taken at any time
  assign cfg.ready = 1'b1;
  assign rsp.data  = out_item;

  cbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (ctl_status),
    .cmd       (ctl_cmd)
  );

  cbc_datapath #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.data),
    .in_item  (req.data),
    .cmd      (ctl_cmd),
    .status   (ctl_status),
    .out_item (out_item)
  );

  // Checks
  `CBC_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item taken while busy")
  `CBC_ASSERT_HOLDS(a_cmd_exclusive, $onehot0({ctl_cmd.step_quot, ctl_cmd.step_rem, ctl_cmd.mem_en, ctl_cmd.load_out, ctl_cmd.latch}), "overlapping datapath commands")
  `CBC_ASSERT_NOW(a_no_overwrite, ctl_cmd.load_out, !rsp.valid || rsp.ready, "pending result overwritten")
  `CBC_ASSERT_NOW(a_fetch_no_data, rsp.valid && rsp.data.rom_fetch, rsp.data.read_data == 8'h00, "ROM fetch with read data")

endmodule

// File: tb/cartridge_bank_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartridge bank controller testbench
// Drives bus access items through the request channel and checks every
// result item against a local model of the bank registers and external RAM.
// A directed pass covers the address window edges and the bank bump cases.
// Random phases follow, each with its own RAM size. Most of the random part
// is setup/write/read-back episodes, and the rest is noise.
// ---------------------------------------------------------------------------
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  localparam int RAM_DEPTH   = 32768;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // Bank register view kept by the model
  typedef struct packed {
    logic        enabled;
    logic        mode;
    logic [6:0]  bank;
    logic [15:0] ram_size;
  } mapper_regs_t;

  localparam mapper_regs_t RESET_REGS = '{enabled: 1'b0, mode: 1'b0, bank: 7'd1,
                                          ram_size: 16'd0};

  logic clk;
  logic rst = 1'b1;

  cbc_req_if req_ch ();
  cbc_rsp_if rsp_ch ();
  cbc_cfg_if cfg_ch ();

  // Testbench-side drivers of the channel inputs
  logic        access_valid = 1'b0;
  req_item_t   access_item  = '0;
  logic        result_ready = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [15:0] cfg_word     = '0;

  assign req_ch.valid = access_valid;
  assign req_ch.data  = access_item;
  assign rsp_ch.ready = result_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data  = cfg_word;

  cartridge_bank_controller #(
    .RAM_DEPTH(RAM_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Model state: plan side follows generation order, live side follows acceptance
  mapper_regs_t plan_regs = RESET_REGS;
  mapper_regs_t live_regs = RESET_REGS;
  logic [7:0]   ram_image [RAM_DEPTH];
  bit           ram_written [RAM_DEPTH];

  req_item_t  access_queue[$];
  rsp_item_t  expected_results[$];

  int   planned_items  = 0;
  int   accepted_items = 0;
  int   mismatches     = 0;
  int   cycle_count    = 0;
  bit   access_taken   = 1'b0;
  bit   result_taken   = 1'b0;
  bit   access_quiet   = 1'b0;
  bit   result_quiet   = 1'b0;
  bit   result_hold    = 1'b0;
  int   access_wait    = 0;
  int   result_wait    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic ram_window_open(mapper_regs_t r, logic [15:0] offset);
    return r.enabled && (offset < r.ram_size);
  endfunction

  // Banked RAM index, wrapped to the RAM depth
  function automatic int ram_slot(mapper_regs_t r, logic [15:0] offset);
    int slot;
    slot = int'(offset);
    if (r.mode) slot += int'(r.bank[6:5]) * 'h2000;
    return slot % RAM_DEPTH;
  endfunction

  function automatic mapper_regs_t bank_control_write(mapper_regs_t r, logic [2:0] sel,
                                                       logic [7:0] d);
    logic [6:0] b;
    case (region_t'(sel[2:1]))
      REGION_RAM_ENABLE: r.enabled = (d[3:0] == ENABLE_KEY);
      REGION_BANK_LOW: begin
        // a zero low field selects bank 1 of that group instead
        b = {r.bank[6:5], d[4:0]};
        if (b[4:0] == 5'd0) b[0] = 1'b1;
        r.bank = b;
      end
      REGION_BANK_HIGH: r.bank = {d[6:5], r.bank[4:0]};
      REGION_MODE: r.mode = (d != 8'd0);
      default: ;
    endcase
    return r;
  endfunction

  // Result of one accepted access; updates the live registers and RAM image
  function automatic rsp_item_t bus_access_result(req_item_t it);
    rsp_item_t  res;
    logic [6:0] rom_bank;
    logic       hit;
    res = '0;
    hit = ram_window_open(live_regs, it.address);
    case (cmd_t'(it.cmd))
      CMD_ROM_READ: begin
        if (it.address < ROM_BANK_BASE) begin
          res.rom_fetch   = 1'b1;
          res.rom_address = 21'(it.address);
        end else if (it.address < ROM_WINDOW_END) begin
          rom_bank = live_regs.mode ? {2'b00, live_regs.bank[4:0]} : live_regs.bank;
          res.rom_fetch   = 1'b1;
          res.rom_address = {rom_bank, it.address[13:0]};
        end else begin
          res.read_data = READ_FILL;
        end
      end
      CMD_CTRL_WRITE: live_regs = bank_control_write(live_regs, it.reg_select, it.write_data);
      CMD_RAM_READ: res.read_data = hit ? ram_image[ram_slot(live_regs, it.address)] : READ_FILL;
      CMD_RAM_WRITE: if (hit) ram_image[ram_slot(live_regs, it.address)] = it.write_data;
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Per-item wait, with occasional switches into and out of a no-wait stretch
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 47) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Queue one access; a read that would hit a never-written RAM entry becomes a write
  task automatic queue_access(cmd_t cmd, logic [15:0] addr, logic [2:0] sel, logic [7:0] data);
    req_item_t it;
    int        slot;
    logic      hit;
    hit  = ram_window_open(plan_regs, addr);
    slot = ram_slot(plan_regs, addr);
    if (cmd == CMD_RAM_READ && hit && !ram_written[slot]) cmd = CMD_RAM_WRITE;
    if (cmd == CMD_RAM_WRITE && hit) ram_written[slot] = 1'b1;
    if (cmd == CMD_CTRL_WRITE) plan_regs = bank_control_write(plan_regs, sel, data);
    it.cmd        = cmd;
    it.address    = addr;
    it.reg_select = sel;
    it.write_data = data;
    access_queue.push_back(it);
    planned_items++;
  endtask

  // Wait until every queued item has been accepted and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_items != planned_items || expected_results.size() != 0);
  endtask

  task automatic write_ram_size(logic [15:0] size);
    @(negedge clk);
    plan_regs.ram_size = size;
    cfg_word  = size;
    cfg_valid = 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Set up banking, write a few offsets, then read them back in random order
  task automatic run_bank_episode();
    logic [15:0] offsets[$];
    logic [15:0] offset;
    int          n;
    int          pick;
    queue_access(CMD_CTRL_WRITE, rand_word(), {REGION_RAM_ENABLE, 1'($urandom)},
                 ($urandom_range(0, 9) == 0) ? 8'($urandom) : {4'($urandom), ENABLE_KEY});
    queue_access(CMD_CTRL_WRITE, rand_word(), {REGION_BANK_LOW, 1'($urandom)},
                 ($urandom_range(0, 3) == 0) ? {3'($urandom), 5'd0} : 8'($urandom));
    queue_access(CMD_CTRL_WRITE, rand_word(), {REGION_BANK_HIGH, 1'($urandom)}, 8'($urandom));
    queue_access(CMD_CTRL_WRITE, rand_word(), {REGION_MODE, 1'($urandom)},
                 ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
    repeat ($urandom_range(1, 4))
      queue_access(CMD_ROM_READ, rand_word(), 3'($urandom), 8'($urandom));
    n = (plan_regs.ram_size == 16'd0) ? 0 : $urandom_range(2, 10);
    repeat (n) begin
      offset = ($urandom_range(0, 9) == 0) ? rand_word()
             : 16'($urandom_range(0, int'(plan_regs.ram_size) - 1));
      offsets.push_back(offset);
      queue_access(CMD_RAM_WRITE, offset, 3'($urandom), 8'($urandom));
    end
    while (offsets.size() > 0) begin
      if ($urandom_range(0, 2) == 0)
        queue_access(CMD_ROM_READ, rand_word(), 3'($urandom), 8'($urandom));
      pick = $urandom_range(0, offsets.size() - 1);
      queue_access(CMD_RAM_READ, offsets[pick], 3'($urandom), 8'($urandom));
      offsets.delete(pick);
    end
  endtask

  task automatic run_noise_burst();
    repeat ($urandom_range(4, 14))
      queue_access(cmd_t'($urandom_range(0, 3)), rand_word(), 3'($urandom), 8'($urandom));
  endtask

  // Sample all three channels at the rising edge; check results, predict accepted items
  always @(posedge clk) begin : bus_monitor
    rsp_item_t want;
    cycle_count++;
    access_taken = 1'b0;
    result_taken = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) live_regs.ram_size = cfg_ch.data;
      if (rsp_ch.valid && rsp_ch.ready) begin
        result_taken = 1'b1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result item with none expected: fetch=%0b addr=%06h data=%02h",
                     $time, rsp_ch.data.rom_fetch, rsp_ch.data.rom_address,
                     rsp_ch.data.read_data);
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.data.rom_fetch !== want.rom_fetch ||
              rsp_ch.data.rom_address !== want.rom_address ||
              rsp_ch.data.read_data !== want.read_data) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch: expected fetch=%0b addr=%06h data=%02h, got fetch=%0b addr=%06h data=%02h",
                       $time, want.rom_fetch, want.rom_address, want.read_data,
                       rsp_ch.data.rom_fetch, rsp_ch.data.rom_address, rsp_ch.data.read_data);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        access_taken = 1'b1;
        accepted_items++;
        expected_results.push_back(bus_access_result(req_ch.data));
      end
    end
  end

  // Request driver: presents queued items at the falling edge with random gaps
  always @(negedge clk) begin : access_driver
    if (!access_valid || access_taken) begin
      if (access_wait > 0) begin
        access_wait--;
        access_valid <= 1'b0;
      end else if (access_queue.size() > 0) begin
        access_item  <= access_queue.pop_front();
        access_valid <= 1'b1;
        access_wait  = draw_wait(access_quiet);
      end else begin
        access_valid <= 1'b0;
      end
    end
  end

  // Result ready: random stall after each taken result, plus the long hold-off
  always @(negedge clk) begin : result_ready_driver
    if (result_taken) result_wait = draw_wait(result_quiet);
    else if (result_wait > 0) result_wait--;
    result_ready <= !result_hold && (result_wait == 0);
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin : result_holdoff
    wait (accepted_items >= HOLD_AT);
    result_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    result_hold = 1'b0;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("cartridge_bank_controller regression: fail");
    $finish;
  end

  initial begin : stimulus
    int ram_sizes [7];
    int target;
    ram_sizes[0] = 0;
    ram_sizes[1] = 1;
    ram_sizes[2] = 2048;
    ram_sizes[3] = 32768;
    ram_sizes[4] = $urandom_range(1, 32768);
    ram_sizes[5] = 8192;
    ram_sizes[6] = 32768;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: window edges, enable key, bank bumps, mode, RAM wrap
    write_ram_size(16'h8000);
    queue_access(CMD_ROM_READ, 16'h0000, 3'd0, 8'h00);
    queue_access(CMD_ROM_READ, 16'h3FFF, 3'd7, 8'hFF);
    queue_access(CMD_ROM_READ, 16'h4000, 3'd0, 8'h00);
    queue_access(CMD_ROM_READ, 16'h7FFF, 3'd0, 8'h00);
    queue_access(CMD_ROM_READ, 16'h8000, 3'd0, 8'h00);
    queue_access(CMD_ROM_READ, 16'hFFFF, 3'd7, 8'hFF);
    // RAM disabled: read refused, write dropped
    queue_access(CMD_RAM_READ, 16'h0000, 3'd0, 8'h00);
    queue_access(CMD_RAM_WRITE, 16'h0000, 3'd0, 8'h55);
    queue_access(CMD_CTRL_WRITE, 16'h0000, {REGION_RAM_ENABLE, 1'b1}, 8'h1A);
    queue_access(CMD_CTRL_WRITE, 16'h0000, {REGION_RAM_ENABLE, 1'b0}, 8'hAB);
    queue_access(CMD_CTRL_WRITE, 16'h0000, {REGION_RAM_ENABLE, 1'b0}, 8'hFA);
    // zero low field, then the 0x60, 0x20 and 0x40 groups
    queue_access(CMD_CTRL_WRITE, 16'h2000, {REGION_BANK_LOW, 1'b0}, 8'h00);
    queue_access(CMD_CTRL_WRITE, 16'h2000, {REGION_BANK_LOW, 1'b1}, 8'hFF);
    queue_access(CMD_CTRL_WRITE, 16'h4000, {REGION_BANK_HIGH, 1'b0}, 8'hFF);
    queue_access(CMD_ROM_READ, 16'h7FFF, 3'd0, 8'h00);
    queue_access(CMD_CTRL_WRITE, 16'h2000, {REGION_BANK_LOW, 1'b0}, 8'hE0);
    queue_access(CMD_CTRL_WRITE, 16'h4000, {REGION_BANK_HIGH, 1'b1}, 8'h20);
    queue_access(CMD_CTRL_WRITE, 16'h2000, {REGION_BANK_LOW, 1'b1}, 8'h00);
    queue_access(CMD_CTRL_WRITE, 16'h4000, {REGION_BANK_HIGH, 1'b0}, 8'h40);
    queue_access(CMD_CTRL_WRITE, 16'h2000, {REGION_BANK_LOW, 1'b0}, 8'h00);
    queue_access(CMD_ROM_READ, 16'h4000, 3'd0, 8'h00);
    // RAM banking mode: ROM uses the low field, RAM the high bits
    queue_access(CMD_CTRL_WRITE, 16'h6000, {REGION_MODE, 1'b0}, 8'h01);
    queue_access(CMD_ROM_READ, 16'h4001, 3'd0, 8'h00);
    queue_access(CMD_RAM_WRITE, 16'h1FFF, 3'd0, 8'hA5);
    queue_access(CMD_RAM_READ, 16'h1FFF, 3'd0, 8'h00);
    // bank group 3 at the top offset wraps onto the same entry
    queue_access(CMD_CTRL_WRITE, 16'h4000, {REGION_BANK_HIGH, 1'b0}, 8'h60);
    queue_access(CMD_RAM_WRITE, 16'h7FFF, 3'd0, 8'h00);
    queue_access(CMD_RAM_READ, 16'h7FFF, 3'd0, 8'h00);
    // offset at the RAM size is refused
    queue_access(CMD_RAM_WRITE, 16'h8000, 3'd0, 8'h3C);
    queue_access(CMD_RAM_READ, 16'h8000, 3'd0, 8'h00);
    queue_access(CMD_CTRL_WRITE, 16'h6000, {REGION_MODE, 1'b1}, 8'h00);
    queue_access(CMD_RAM_WRITE, 16'h5FFF, 3'd0, 8'hFF);
    queue_access(CMD_RAM_READ, 16'h5FFF, 3'd0, 8'h00);

    // Random phases, one RAM size each
    foreach (ram_sizes[p]) begin
      wait_idle();
      write_ram_size(16'(ram_sizes[p]));
      target = planned_items + PHASE_ITEMS;
      while (planned_items < target) begin
        if ($urandom_range(0, 9) < 7) run_bank_episode();
        else run_noise_burst();
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("cartridge_bank_controller regression: pass");
    end else begin
      $display("cartridge_bank_controller regression: fail");
    end
    $finish;
  end

endmodule
